### sv/gemm_scaled_accumulate_top_defines.svh
// assertion macros used by the gemm scaled accumulate sequencer
`ifndef GEMM_SCALED_ACCUMULATE_TOP_DEFINES_SVH
`define GEMM_SCALED_ACCUMULATE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define GSA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define GSA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define GSA_ASSERT(label, clk, rst_n, prop, msg)

`define GSA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### sv/gsa_pkg.sv
// package with widths, codes and helpers of the gemm scaled accumulate block
`timescale 1ns / 1ps
`default_nettype none

package gsa_pkg;

	localparam int MAX_DIM     = 16;
	localparam int DIM_CAP     = (MAX_DIM < 16) ? MAX_DIM : 16;
	localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam int IDX_W   = 4;
	localparam int DIM_W   = 5;
	localparam int ELEM_W  = 16;
	localparam int FRAC_W  = 8;
	localparam int ACC_W   = 2 * ELEM_W + 4;
	localparam int MUL_W   = ACC_W + ELEM_W;
	localparam int TOT_W   = MUL_W;
	localparam int OUT_W   = 32;
	localparam int REG_IDX_W = 3;
	localparam int CFG_W   = 16;

	localparam logic [DIM_W-1:0] DIM_CAP_V = DIM_W'(DIM_CAP);

	// opcodes of an input item
	localparam logic [1:0] OP_LOAD_A  = 2'd0;
	localparam logic [1:0] OP_LOAD_B  = 2'd1;
	localparam logic [1:0] OP_LOAD_C  = 2'd2;
	localparam logic [1:0] OP_COMPUTE = 2'd3;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_ROWS_M  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COLS_N  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_INNER_K = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ALPHA   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BETA    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_B_TRANS = 3'd5;

	// operand selection of the shared multiplier
	localparam logic [1:0] MUL_AB    = 2'd0;
	localparam logic [1:0] MUL_ALPHA = 2'd1;
	localparam logic [1:0] MUL_BETA  = 2'd2;

	typedef struct packed {
		logic [1:0] mul_sel;
		logic       prod_en;
		logic       acc_clr;
		logic       acc_add;
		logic       tot_shift;
		logic       tot_add;
	} dp_ctrl_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		if (v == '0)
			return DIM_W'(1);
		else if (v > DIM_CAP_V)
			return DIM_CAP_V;
		else
			return v;
	endfunction

	function automatic logic [ADDR_W-1:0] mem_addr(input logic [IDX_W-1:0] row,
		input logic [IDX_W-1:0] col);
		return ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col);
	endfunction

endpackage

`default_nettype wire

### sv/gsa_ram.sv
// element store: one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module gsa_ram (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [gsa_pkg::ADDR_W-1:0] waddr,
	input  wire logic [gsa_pkg::ELEM_W-1:0] wdata,
	input  wire logic                      re,
	input  wire logic [gsa_pkg::ADDR_W-1:0] raddr,
	output logic      [gsa_pkg::ELEM_W-1:0] rdata
);
	import gsa_pkg::*;

	logic [ELEM_W-1:0] mem_q [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### sv/gsa_datapath.sv
// shared multiplier, accumulator, scaling sum and saturation
`timescale 1ns / 1ps
`default_nettype none

module gsa_datapath (
	input  wire logic                             clk,
	input  wire gsa_pkg::dp_ctrl_t                ctrl,
	input  wire logic signed [gsa_pkg::ELEM_W-1:0] a_data,
	input  wire logic signed [gsa_pkg::ELEM_W-1:0] b_data,
	input  wire logic signed [gsa_pkg::ELEM_W-1:0] c_data,
	input  wire logic signed [gsa_pkg::ELEM_W-1:0] alpha,
	input  wire logic signed [gsa_pkg::ELEM_W-1:0] beta,
	output logic signed      [gsa_pkg::OUT_W-1:0]  res_value,
	output logic                                  res_sat
);
	import gsa_pkg::*;

	logic signed [ACC_W-1:0]  mul_x;
	logic signed [ELEM_W-1:0] mul_y;
	logic signed [MUL_W-1:0]  mul_p;
	logic signed [MUL_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [TOT_W-1:0]  tot_q;
	logic [TOT_W-OUT_W:0]     tot_hi;
	logic                     ovf;

	always_comb begin
		case (ctrl.mul_sel)
			MUL_AB: begin
				mul_x = ACC_W'(a_data);
				mul_y = b_data;
			end
			MUL_ALPHA: begin
				mul_x = acc_q;
				mul_y = alpha;
			end
			MUL_BETA: begin
				mul_x = ACC_W'(c_data);
				mul_y = beta;
			end
			default: begin
				mul_x = ACC_W'(a_data);
				mul_y = b_data;
			end
		endcase
	end

	assign mul_p = mul_x * mul_y;

	always_ff @(posedge clk) begin
		if (ctrl.prod_en) begin
			prod_q <= mul_p;
		end
		if (ctrl.acc_clr) begin
			acc_q <= '0;
		end else if (ctrl.acc_add) begin
			// element products fit the low bits of the product register
			acc_q <= acc_q + $signed(prod_q[ACC_W-1:0]);
		end
		if (ctrl.tot_shift) begin
			tot_q <= prod_q >>> FRAC_W;
		end else if (ctrl.tot_add) begin
			tot_q <= tot_q + prod_q;
		end
	end

	// clip when the result sign bit and the bits above it disagree
	assign tot_hi = tot_q[TOT_W-1:OUT_W-1];
	assign ovf    = !((&tot_hi) || !(|tot_hi));

	always_comb begin
		res_sat = ovf;
		if (!ovf)
			res_value = tot_q[OUT_W-1:0];
		else if (tot_q[TOT_W-1])
			res_value = {1'b1, {(OUT_W-1){1'b0}}};
		else
			res_value = {1'b0, {(OUT_W-1){1'b1}}};
	end

endmodule

`default_nettype wire

### sv/gsa_seq.sv
// sequencer: walks columns and inner terms of a result row
`timescale 1ns / 1ps
`default_nettype none
`include "gemm_scaled_accumulate_top_defines.svh"

module gsa_seq (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [gsa_pkg::IDX_W-1:0]   start_row,
	input  wire logic [gsa_pkg::IDX_W-1:0]   n_last,
	input  wire logic [gsa_pkg::IDX_W-1:0]   k_last,
	input  wire logic                        b_trans,
	input  wire logic                        out_free,
	output logic                             busy,
	output logic                             ab_re,
	output logic [gsa_pkg::ADDR_W-1:0]       a_raddr,
	output logic [gsa_pkg::ADDR_W-1:0]       b_raddr,
	output logic                             c_re,
	output logic [gsa_pkg::ADDR_W-1:0]       c_raddr,
	output gsa_pkg::dp_ctrl_t                ctrl,
	output logic                             out_load,
	output logic [gsa_pkg::IDX_W-1:0]        out_row,
	output logic [gsa_pkg::IDX_W-1:0]        out_col,
	output logic                             out_last
);
	import gsa_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MAC   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_ALPHA = 3'd3;
	localparam logic [2:0] ST_BETA  = 3'd4;
	localparam logic [2:0] ST_SUM   = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] l_q;
	logic             rd_v_s1;
	logic             mul_v_s2;

	assign busy     = (state_q != ST_IDLE);
	assign out_row  = row_q;
	assign out_col  = j_q;
	assign out_last = (j_q == n_last);

	assign ab_re   = (state_q == ST_MAC);
	assign a_raddr = mem_addr(row_q, l_q);
	assign b_raddr = b_trans ? mem_addr(j_q, l_q) : mem_addr(l_q, j_q);
	// prior c is fetched once per column and held in the read register
	assign c_re    = (state_q == ST_MAC) && (l_q == '0);
	assign c_raddr = mem_addr(row_q, j_q);

	always_comb begin
		ctrl.mul_sel   = MUL_AB;
		ctrl.prod_en   = rd_v_s1;
		ctrl.acc_clr   = start;
		ctrl.acc_add   = mul_v_s2;
		ctrl.tot_shift = 1'b0;
		ctrl.tot_add   = 1'b0;
		out_load       = 1'b0;
		case (state_q)
			ST_ALPHA: begin
				ctrl.mul_sel = MUL_ALPHA;
				ctrl.prod_en = 1'b1;
				ctrl.acc_clr = 1'b1;
			end
			ST_BETA: begin
				ctrl.mul_sel   = MUL_BETA;
				ctrl.prod_en   = 1'b1;
				ctrl.tot_shift = 1'b1;
			end
			ST_SUM: begin
				ctrl.tot_add = 1'b1;
			end
			ST_OUT: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			row_q    <= '0;
			j_q      <= '0;
			l_q      <= '0;
			rd_v_s1  <= 1'b0;
			mul_v_s2 <= 1'b0;
		end else begin
			rd_v_s1  <= (state_q == ST_MAC);
			mul_v_s2 <= rd_v_s1;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						row_q   <= start_row;
						j_q     <= '0;
						l_q     <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (l_q == k_last) begin
						state_q <= ST_DRAIN;
					end else begin
						l_q <= l_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (!rd_v_s1 && !mul_v_s2) begin
						state_q <= ST_ALPHA;
					end
				end
				ST_ALPHA: begin
					state_q <= ST_BETA;
				end
				ST_BETA: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						if (j_q == n_last) begin
							state_q <= ST_IDLE;
						end else begin
							j_q     <= j_q + IDX_W'(1);
							l_q     <= '0;
							state_q <= ST_MAC;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`GSA_ASSERT_IMPL(a_alpha_pipe_empty, clk, arst_n, state_q == ST_ALPHA, !rd_v_s1 && !mul_v_s2, "alpha multiply while product pipeline busy")
	`GSA_ASSERT_IMPL(a_start_idle, clk, arst_n, start, state_q == ST_IDLE, "compute started while busy")
	`GSA_ASSERT_IMPL(a_inner_bound, clk, arst_n, state_q == ST_MAC, l_q <= k_last, "inner index past k")
	`GSA_ASSERT(a_col_bound, clk, arst_n, (state_q == ST_IDLE) || (j_q <= n_last), "column index past n")

endmodule

`default_nettype wire

### sv/gemm_scaled_accumulate_top.sv
// top level of the fixed-point alpha/beta matrix multiply-accumulate block
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata row,col,elem; tuser opcode
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata row,col,value; tuser sat; tlast
// cfg       in   cfg_we                         cfg_index, cfg_data
//
// a load is written to its store as it is taken; a compute row runs through the
// single shared multiplier, which does every a*b term, then alpha and beta in turn
// the stores have no reset and need no clearing pass; ready is low while a row runs
// a stalled result holds the output register and the sequencer waits before the
// next column; a new item is still taken while the last result waits
`timescale 1ns / 1ps
`default_nettype none

module gemm_scaled_accumulate_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [23:0]                     s_axis_tdata,  // row_index, col_index, elem_value
	input  wire logic [1:0]                      s_axis_tuser,  // opcode
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [39:0]                          m_axis_tdata,  // out_row, out_col, out_value
	output logic                                 m_axis_tuser,  // was_saturated
	output logic                                 m_axis_tlast,
	input  wire logic                            cfg_we,
	input  wire logic [gsa_pkg::REG_IDX_W-1:0]   cfg_index,
	input  wire logic [gsa_pkg::CFG_W-1:0]       cfg_data
);
	import gsa_pkg::*;

	logic [DIM_W-1:0]         rows_m_q;
	logic [DIM_W-1:0]         cols_n_q;
	logic [DIM_W-1:0]         inner_k_q;
	logic signed [ELEM_W-1:0] alpha_q;
	logic signed [ELEM_W-1:0] beta_q;
	logic                     b_trans_q;

	logic [1:0]               opcode;
	logic [IDX_W-1:0]         row_index;
	logic [IDX_W-1:0]         col_index;
	logic [ELEM_W-1:0]        elem_value;
	logic                     in_xfer;
	logic                     in_range;
	logic [ADDR_W-1:0]        waddr;
	logic                     we_a;
	logic                     we_b;
	logic                     we_c;
	logic                     start;
	logic [DIM_W-1:0]         m_cl;
	logic [DIM_W-1:0]         n_cl;
	logic [DIM_W-1:0]         k_cl;
	logic [DIM_W-1:0]         n_m1;
	logic [DIM_W-1:0]         k_m1;

	logic                     busy;
	logic                     ab_re;
	logic [ADDR_W-1:0]        a_raddr;
	logic [ADDR_W-1:0]        b_raddr;
	logic                     c_re;
	logic [ADDR_W-1:0]        c_raddr;
	logic [ELEM_W-1:0]        a_rd;
	logic [ELEM_W-1:0]        b_rd;
	logic [ELEM_W-1:0]        c_rd;
	dp_ctrl_t                 ctrl;
	logic                     out_load;
	logic                     out_free;
	logic [IDX_W-1:0]         seq_row;
	logic [IDX_W-1:0]         seq_col;
	logic                     seq_last;
	logic signed [OUT_W-1:0]  res_value;
	logic                     res_sat;

	logic                     out_valid_q;
	logic [IDX_W-1:0]         out_row_q;
	logic [IDX_W-1:0]         out_col_q;
	logic [OUT_W-1:0]         out_value_q;
	logic                     out_sat_q;
	logic                     out_last_q;

	assign opcode     = s_axis_tuser;
	assign row_index  = s_axis_tdata[3:0];
	assign col_index  = s_axis_tdata[7:4];
	assign elem_value = s_axis_tdata[23:8];

	assign s_axis_tready = !busy;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_m_q  <= DIM_W'(16);
			cols_n_q  <= DIM_W'(16);
			inner_k_q <= DIM_W'(16);
			alpha_q   <= ELEM_W'(256);
			beta_q    <= '0;
			b_trans_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS_M:  rows_m_q  <= cfg_data[DIM_W-1:0];
				REG_COLS_N:  cols_n_q  <= cfg_data[DIM_W-1:0];
				REG_INNER_K: inner_k_q <= cfg_data[DIM_W-1:0];
				REG_ALPHA:   alpha_q   <= cfg_data[ELEM_W-1:0];
				REG_BETA:    beta_q    <= cfg_data[ELEM_W-1:0];
				REG_B_TRANS: b_trans_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign m_cl = clamp_dim(rows_m_q);
	assign n_cl = clamp_dim(cols_n_q);
	assign k_cl = clamp_dim(inner_k_q);
	assign n_m1 = n_cl - DIM_W'(1);
	assign k_m1 = k_cl - DIM_W'(1);

	// loads outside the stored square are dropped
	assign in_range = ({1'b0, row_index} < DIM_CAP_V) && ({1'b0, col_index} < DIM_CAP_V);
	assign waddr    = mem_addr(row_index, col_index);
	assign we_a     = in_xfer && (opcode == OP_LOAD_A) && in_range;
	assign we_b     = in_xfer && (opcode == OP_LOAD_B) && in_range;
	assign we_c     = in_xfer && (opcode == OP_LOAD_C) && in_range;
	assign start    = in_xfer && (opcode == OP_COMPUTE) && ({1'b0, row_index} < m_cl);

	gsa_ram u_a_ram (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (elem_value),
		.re    (ab_re),
		.raddr (a_raddr),
		.rdata (a_rd)
	);

	gsa_ram u_b_ram (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (elem_value),
		.re    (ab_re),
		.raddr (b_raddr),
		.rdata (b_rd)
	);

	gsa_ram u_c_ram (
		.clk   (clk),
		.we    (we_c),
		.waddr (waddr),
		.wdata (elem_value),
		.re    (c_re),
		.raddr (c_raddr),
		.rdata (c_rd)
	);

	gsa_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.start_row (row_index),
		.n_last    (n_m1[IDX_W-1:0]),
		.k_last    (k_m1[IDX_W-1:0]),
		.b_trans   (b_trans_q),
		.out_free  (out_free),
		.busy      (busy),
		.ab_re     (ab_re),
		.a_raddr   (a_raddr),
		.b_raddr   (b_raddr),
		.c_re      (c_re),
		.c_raddr   (c_raddr),
		.ctrl      (ctrl),
		.out_load  (out_load),
		.out_row   (seq_row),
		.out_col   (seq_col),
		.out_last  (seq_last)
	);

	gsa_datapath u_dp (
		.clk       (clk),
		.ctrl      (ctrl),
		.a_data    ($signed(a_rd)),
		.b_data    ($signed(b_rd)),
		.c_data    ($signed(c_rd)),
		.alpha     (alpha_q),
		.beta      (beta_q),
		.res_value (res_value),
		.res_sat   (res_sat)
	);

	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_row_q   <= seq_row;
			out_col_q   <= seq_col;
			out_value_q <= res_value;
			out_sat_q   <= res_sat;
			out_last_q  <= seq_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_value_q, out_col_q, out_row_q};
	assign m_axis_tuser  = out_sat_q;
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

### tb/gemm_scaled_accumulate_top_tb.sv
// testbench of the fixed-point alpha/beta matrix multiply-accumulate block
`timescale 1ns / 1ps
`default_nettype none

module gemm_scaled_accumulate_top_tb;
	import gsa_pkg::*;

	localparam int SETTLE_CYCLES = MAX_DIM * (MAX_DIM + 7) + 16;
	localparam int ITEM_TARGET = 410;
	localparam int SEGMENT_ITEMS = 35;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct {
		logic [3:0]  row;
		logic [3:0]  col;
		logic [31:0] value;
		logic        sat;
		logic        last;
	} row_result_t;

	class gemm_row_board;
		logic signed [15:0] a_mem [MAX_DIM*MAX_DIM];
		logic signed [15:0] b_mem [MAX_DIM*MAX_DIM];
		logic signed [15:0] c_mem [MAX_DIM*MAX_DIM];
		bit a_set [MAX_DIM*MAX_DIM];
		bit b_set [MAX_DIM*MAX_DIM];
		bit c_set [MAX_DIM*MAX_DIM];
		logic [4:0] rows_m, cols_n, inner_k;
		logic signed [15:0] alpha, beta;
		bit b_trans;
		row_result_t pending_results[$];
		int errors;

		function new();
			rows_m = 5'd16;
			cols_n = 5'd16;
			inner_k = 5'd16;
			alpha = 16'sd256;
			beta = 16'sd0;
			b_trans = 1'b0;
			errors = 0;
		endfunction

		function int eff_dim(logic [4:0] v);
			if (v == 5'd0)
				return 1;
			if (v > DIM_CAP)
				return DIM_CAP;
			return int'(v);
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_ROWS_M:  rows_m = data[4:0];
				REG_COLS_N:  cols_n = data[4:0];
				REG_INNER_K: inner_k = data[4:0];
				REG_ALPHA:   alpha = data;
				REG_BETA:    beta = data;
				REG_B_TRANS: b_trans = data[0];
				default: ;
			endcase
		endfunction

		// stores a load, or queues the whole row that a compute produces; out-of-range items are dropped
		function void take_item(logic [1:0] op, logic [3:0] row, logic [3:0] col,
			logic [15:0] val);
			int r, addr, m, n, k, bi;
			longint acc, total;
			row_result_t res;
			r = int'(row);
			addr = r * MAX_DIM + int'(col);
			if (op != OP_COMPUTE) begin
				if (r >= DIM_CAP || int'(col) >= DIM_CAP)
					return;
				case (op)
					OP_LOAD_A: begin
						a_mem[addr] = val;
						a_set[addr] = 1'b1;
					end
					OP_LOAD_B: begin
						b_mem[addr] = val;
						b_set[addr] = 1'b1;
					end
					default: begin
						c_mem[addr] = val;
						c_set[addr] = 1'b1;
					end
				endcase
				return;
			end
			m = eff_dim(rows_m);
			n = eff_dim(cols_n);
			k = eff_dim(inner_k);
			if (r >= m)
				return;
			for (int j = 0; j < n; j++) begin
				acc = 0;
				for (int l = 0; l < k; l++) begin
					bi = b_trans ? j * MAX_DIM + l : l * MAX_DIM + j;
					acc += longint'(a_mem[r * MAX_DIM + l]) * longint'(b_mem[bi]);
				end
				// arithmetic shift floors negative products
				total = ((acc * longint'(alpha)) >>> 8)
					+ longint'(beta) * longint'(c_mem[r * MAX_DIM + j]);
				res.sat = 1'b0;
				if (total > 64'sd2147483647) begin
					total = 64'sd2147483647;
					res.sat = 1'b1;
				end else if (total < -64'sd2147483648) begin
					total = -64'sd2147483648;
					res.sat = 1'b1;
				end
				res.row = row;
				res.col = 4'(j);
				res.value = total[31:0];
				res.last = (j == n - 1);
				pending_results.push_back(res);
			end
		endfunction

		function void field_check(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			end
		endfunction

		function void check_result(logic [39:0] data, logic sat, logic last);
			row_result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected transfer, expected none actual row %0d col %0d value %h",
					$time, data[3:0], data[7:4], data[39:8]);
				return;
			end
			want = pending_results.pop_front();
			field_check("out_row", 32'(want.row), 32'(data[3:0]));
			field_check("out_col", 32'(want.col), 32'(data[7:4]));
			field_check("out_value", want.value, data[39:8]);
			field_check("was_saturated", 32'(want.sat), 32'(sat));
			field_check("last_of_row", 32'(want.last), 32'(last));
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [23:0]          s_axis_tdata = '0;  // row_index, col_index, elem_value
	logic [1:0]           s_axis_tuser = OP_LOAD_A;  // opcode
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [39:0]          m_axis_tdata;  // out_row, out_col, out_value
	logic                 m_axis_tuser;  // was_saturated
	logic                 m_axis_tlast;
	logic                 cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = REG_ROWS_M;
	logic [CFG_W-1:0]     cfg_data = '0;

	gemm_row_board board;
	int items_sent = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	gemm_scaled_accumulate_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
	end

	function automatic logic [15:0] rand_elem();
		int pick;
		pick = $urandom_range(99);
		if (pick < 60)
			return 16'($urandom_range(4095) - 2048);
		if (pick < 85)
			return 16'($urandom);
		case ($urandom_range(3))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			default: return 16'hffff;
		endcase
	endfunction

	function automatic logic [15:0] rand_scale();
		int pick;
		pick = $urandom_range(99);
		if (pick < 40)
			return 16'($urandom_range(1023) - 512);
		if (pick < 70)
			return 16'($urandom);
		case ($urandom_range(4))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0100;
			3: return 16'h0000;
			default: return 16'hff00;
		endcase
	endfunction

	function automatic logic [4:0] rand_dim();
		if ($urandom_range(99) < 70)
			return 5'($urandom_range(4, 1));
		case ($urandom_range(3))
			0: return 5'd0;
			1: return 5'd16;
			2: return 5'd31;
			default: return 5'($urandom_range(31));
		endcase
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [3:0] row,
		input logic [3:0] col, input logic [15:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {val, col, row};
		s_axis_tuser <= op;
		do
			@(posedge clk);
		while (!s_axis_tready);
		board.take_item(op, row, col, val);
		items_sent++;
	endtask

	// wait for every queued result, then a quiet stretch before register writes
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (board.pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		board.write_reg(idx, data);
	endtask

	// unused upper bits of the narrow registers carry noise
	task automatic configure(input logic [4:0] m, input logic [4:0] n, input logic [4:0] k,
		input logic [15:0] alpha, input logic [15:0] beta, input logic bt);
		wait_drained();
		write_reg(REG_ROWS_M, {11'($urandom), m});
		write_reg(REG_COLS_N, {11'($urandom), n});
		write_reg(REG_INNER_K, {11'($urandom), k});
		write_reg(REG_ALPHA, alpha);
		write_reg(REG_BETA, beta);
		write_reg(REG_B_TRANS, {15'($urandom), bt});
		write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	// loads whatever row r still lacks, rewrites a few entries, then computes it
	task automatic run_row(input int r);
		int n, k, pick, j, l, ar, ac;
		n = board.eff_dim(board.cols_n);
		k = board.eff_dim(board.inner_k);
		for (int i = 0; i < k; i++)
			if (!board.a_set[r * MAX_DIM + i])
				send_item(OP_LOAD_A, 4'(r), 4'(i), rand_elem());
		for (int jj = 0; jj < n; jj++)
			for (int ll = 0; ll < k; ll++) begin
				ar = board.b_trans ? jj : ll;
				ac = board.b_trans ? ll : jj;
				if (!board.b_set[ar * MAX_DIM + ac])
					send_item(OP_LOAD_B, 4'(ar), 4'(ac), rand_elem());
			end
		for (int i = 0; i < n; i++)
			if (!board.c_set[r * MAX_DIM + i])
				send_item(OP_LOAD_C, 4'(r), 4'(i), rand_elem());
		repeat ($urandom_range(3)) begin
			pick = $urandom_range(2);
			j = $urandom_range(n - 1);
			l = $urandom_range(k - 1);
			if (pick == 0)
				send_item(OP_LOAD_A, 4'(r), 4'(l), rand_elem());
			else if (pick == 1)
				send_item(OP_LOAD_B, board.b_trans ? 4'(j) : 4'(l),
					board.b_trans ? 4'(l) : 4'(j), rand_elem());
			else
				send_item(OP_LOAD_C, 4'(r), 4'(j), rand_elem());
		end
		send_item(OP_COMPUTE, 4'(r), 4'($urandom), 16'($urandom));
	endtask

	task automatic run_segment(input int budget);
		int start, m;
		logic [1:0] op;
		start = items_sent;
		while (items_sent - start < budget) begin
			m = board.eff_dim(board.rows_m);
			if ($urandom_range(99) < 80) begin
				run_row($urandom_range(m - 1));
			end else if ($urandom_range(1) == 0 || m >= DIM_CAP) begin
				case ($urandom_range(2))
					0: op = OP_LOAD_A;
					1: op = OP_LOAD_B;
					default: op = OP_LOAD_C;
				endcase
				send_item(op, 4'($urandom), 4'($urandom), 16'($urandom));
			end else begin
				// row beyond rows_m, no transfer comes back
				send_item(OP_COMPUTE, 4'($urandom_range(15, m)), 4'($urandom), 16'($urandom));
			end
		end
	endtask

	initial begin
		#12_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int seg;
		logic [4:0] m, n, k;
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// clipping at both ends and floor rounding on a single-term row
		configure(5'd16, 5'd1, 5'd1, 16'h7fff, 16'h7fff, 1'b0);
		send_item(OP_LOAD_A, 4'd15, 4'd0, 16'h8000);
		send_item(OP_LOAD_B, 4'd0, 4'd0, 16'h8000);
		send_item(OP_LOAD_C, 4'd15, 4'd0, 16'h7fff);
		send_item(OP_COMPUTE, 4'd15, 4'd0, 16'h0000);
		send_item(OP_LOAD_A, 4'd15, 4'd0, 16'h7fff);
		send_item(OP_LOAD_C, 4'd15, 4'd0, 16'h8000);
		send_item(OP_COMPUTE, 4'd15, 4'd15, 16'hffff);
		send_item(OP_LOAD_A, 4'd15, 4'd0, 16'h0001);
		send_item(OP_LOAD_B, 4'd0, 4'd0, 16'hffff);
		send_item(OP_LOAD_C, 4'd15, 4'd0, 16'h0001);
		send_item(OP_COMPUTE, 4'd15, 4'd0, 16'h0000);
		send_item(OP_LOAD_B, 4'd15, 4'd15, 16'h5a5a);

		// zero rows acts as one, transposed b, negative full-scale alpha and beta
		configure(5'd0, 5'd2, 5'd2, 16'h8000, 16'h8000, 1'b1);
		run_row(0);
		send_item(OP_COMPUTE, 4'd1, 4'd0, 16'h0000);
		send_item(OP_COMPUTE, 4'd15, 4'd15, 16'h7fff);

		seg = 0;
		while (items_sent < ITEM_TARGET) begin
			if (seg == 0) begin
				configure(5'd31, 5'd31, 5'd1, 16'h7fff, 16'h8000, 1'b0);
			end else if (seg == 1) begin
				configure(5'd16, 5'd1, 5'd31, 16'h8000, 16'h7fff, 1'b1);
			end else begin
				m = rand_dim();
				n = rand_dim();
				k = rand_dim();
				if (board.eff_dim(n) * board.eff_dim(k) > 64)
					k = 5'($urandom_range(4, 1));
				configure(m, n, k, rand_scale(), rand_scale(), 1'($urandom));
			end
			case (seg % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 86;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 86;
				end
				default: begin
					send_idle_pct = 22;
					stall_pct = 22;
				end
			endcase
			run_segment(SEGMENT_ITEMS);
			seg++;
		end

		wait_drained();
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
+incdir+sv
sv/gsa_pkg.sv
sv/gsa_ram.sv
sv/gsa_datapath.sv
sv/gsa_seq.sv
sv/gemm_scaled_accumulate_top.sv
tb/gemm_scaled_accumulate_top_tb.sv
